/* hdl/lph_pkg.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Shared request, response and controller/datapath interface types.
// ----------------------------------------------------------------------------
package lph_pkg;

    localparam int unsigned KEY_W  = 31;
    localparam int unsigned SLOT_W = 6;
    localparam int unsigned SPAN_W = 7;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_ZERO_KEY  = 3'd4
    } t_status;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_SEARCH = 1'b1
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [KEY_W-1:0]  key;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key_echo;
    } t_rsp;

    typedef struct packed {
        logic    load;
        logic    hash_step;
        logic    reduce_step;
        logic    probe_first;
        logic    probe_next;
        logic    write_key;
        logic    clear_step;
        logic    respond;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic key_zero;
        logic hash_last;
        logic home_ready;
        logic hit_match;
        logic hit_empty;
        logic last_probe;
        logic is_search;
    } t_dp_stat;

endpackage

/* hdl/lph_dp.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Key store, hash remainder unit, probe index and response register.
// ----------------------------------------------------------------------------
module lph_dp #(
    parameter int unsigned TABLE_DEPTH  = 64,
    parameter int unsigned HASH_MODULUS = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lph_pkg::t_req             i_req,
    input  logic                      i_cfg_we,
    input  logic [lph_pkg::SPAN_W-1:0] i_cfg_wdata,
    input  lph_pkg::t_dp_cmd          i_cmd,
    output lph_pkg::t_dp_stat         o_stat,
    output lph_pkg::t_rsp             o_rsp
);
    import lph_pkg::*;

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned SW = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CW = (SW > SPAN_W) ? SW : SPAN_W;
    localparam int unsigned RW = $clog2(HASH_MODULUS) + 1;
    localparam int unsigned HW = (RW > SW) ? RW : SW;
    localparam int unsigned PW = IW + 1;
    localparam logic [CW-1:0] HM_C    = CW'(HASH_MODULUS);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [HW-1:0] HM_H    = HW'(HASH_MODULUS);
    localparam logic [IW-1:0] LAST_ROW = IW'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0]  r_mem [TABLE_DEPTH];
    logic [KEY_W-1:0]  r_rdata;
    logic [SPAN_W-1:0] r_table_span;
    logic [SW-1:0]     r_span;
    logic [KEY_W-1:0]  r_key;
    t_func             r_func;
    logic [1:0]        r_hcnt;
    logic [HW-1:0]     r_home;
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     r_pcnt;
    logic [IW-1:0]     r_clr;
    t_rsp              r_rsp;

    logic [CW-1:0]     eff_span;
    logic [HW-1:0]     n_home_hash;
    logic [7:0]        key_byte;
    logic [31:0]       key_pad;
    logic [PW-1:0]     span_p;
    logic [PW-1:0]     idx_inc;
    logic [IW-1:0]     idx_next;
    logic [IW-1:0]     rd_addr;
    logic [IW+SLOT_W-1:0] slot_wide;

    // Configured span raised to the modulus and capped at the store depth.
    always_comb begin
        eff_span = CW'(r_table_span);
        if (eff_span < HM_C) begin
            eff_span = HM_C;
        end
        if (eff_span > DEPTH_C) begin
            eff_span = DEPTH_C;
        end
    end

    // Eight bits of the key per step, restoring remainder one bit at a time.
    always_comb begin
        logic [HW-1:0] rem;
        key_pad  = {1'b0, r_key};
        key_byte = key_pad[8*(3-r_hcnt) +: 8];
        rem      = r_home;
        for (int i = 7; i >= 0; i--) begin
            rem = {rem[HW-2:0], key_byte[i]};
            if (rem >= HM_H) begin
                rem = rem - HM_H;
            end
        end
        n_home_hash = rem;
    end

    assign span_p   = PW'(r_span);
    assign idx_inc  = {1'b0, r_idx} + PW'(1);
    assign idx_next = (idx_inc == span_p) ? '0 : idx_inc[IW-1:0];
    assign rd_addr  = i_cmd.probe_first ? r_home[IW-1:0] : idx_next;
    assign slot_wide = {{SLOT_W{1'b0}}, r_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem[r_clr] <= '0;
        end else if (i_cmd.write_key) begin
            r_mem[r_idx] <= r_key;
        end
        if (i_cmd.probe_first || i_cmd.probe_next) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_span <= SPAN_W'(64);
            r_clr        <= '0;
            r_hcnt       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_span <= i_cfg_wdata;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.load) begin
                r_hcnt <= '0;
            end else if (i_cmd.hash_step) begin
                r_hcnt <= r_hcnt + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_req.key;
            r_func <= i_req.func;
            r_span <= SW'(eff_span);
            r_home <= '0;
        end else if (i_cmd.hash_step) begin
            r_home <= n_home_hash;
        end else if (i_cmd.reduce_step) begin
            r_home <= r_home - HW'(r_span);
        end
        if (i_cmd.probe_first) begin
            r_idx  <= r_home[IW-1:0];
            r_pcnt <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx  <= idx_next;
            r_pcnt <= r_pcnt + IW'(1);
        end
        if (i_cmd.respond) begin
            r_rsp.status   <= i_cmd.status;
            r_rsp.key_echo <= r_key;
            if (i_cmd.status == ST_INSERTED || i_cmd.status == ST_FOUND) begin
                r_rsp.slot <= slot_wide[SLOT_W-1:0];
            end else begin
                r_rsp.slot <= '0;
            end
        end
    end

    assign o_stat.clear_done = (r_clr == LAST_ROW);
    assign o_stat.key_zero   = (r_key == '0);
    assign o_stat.hash_last  = (r_hcnt == 2'd3);
    assign o_stat.home_ready = (r_home < HW'(r_span));
    assign o_stat.hit_match  = (r_rdata == r_key);
    assign o_stat.hit_empty  = (r_rdata == '0);
    assign o_stat.last_probe = ({1'b0, r_pcnt} == span_p - PW'(1));
    assign o_stat.is_search  = (r_func == FN_SEARCH);
    assign o_rsp             = r_rsp;

endmodule

/* hdl/lph_ctrl.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences the clearing sweep, hashing, home reduction and probing.
// ----------------------------------------------------------------------------
module lph_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lph_pkg::t_dp_stat  i_stat,
    output lph_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    import lph_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_REDUCE,
        S_PROBE
    } t_state;

    t_state  r_state, n_state;
    logic    r_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        cmd.status = ST_INSERTED;
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    cmd.load = 1'b1;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                if (i_stat.key_zero) begin
                    cmd.respond = 1'b1;
                    cmd.status  = ST_ZERO_KEY;
                    n_state     = S_IDLE;
                end else begin
                    cmd.hash_step = 1'b1;
                    if (i_stat.hash_last) begin
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (i_stat.home_ready) begin
                    cmd.probe_first = 1'b1;
                    n_state         = S_PROBE;
                end else begin
                    cmd.reduce_step = 1'b1;
                end
            end
            S_PROBE: begin
                if (!i_stat.is_search) begin
                    if (i_stat.hit_empty) begin
                        cmd.write_key = 1'b1;
                        cmd.respond   = 1'b1;
                        cmd.status    = ST_INSERTED;
                        n_state       = S_IDLE;
                    end else if (i_stat.last_probe) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_FULL;
                        n_state     = S_IDLE;
                    end else begin
                        cmd.probe_next = 1'b1;
                    end
                end else begin
                    if (i_stat.hit_match) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_FOUND;
                        n_state     = S_IDLE;
                    end else if (i_stat.hit_empty || i_stat.last_probe) begin
                        cmd.respond = 1'b1;
                        cmd.status  = ST_NOT_FOUND;
                        n_state     = S_IDLE;
                    end else begin
                        cmd.probe_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= cmd.respond;
        end
    end

    assign o_cmd   = cmd;
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

endmodule

/* hdl/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// Linear probe hash table core
// Open addressing hash table with linear probing over a configurable span.
//
//   Channel   Signals                      Transfer when
//   request   start, busy, i_req           start high and busy low
//   result    o_valid, o_rsp               o_valid high (one cycle, no stall)
//   config    i_cfg_we, i_cfg_wdata        i_cfg_we high
//
// A request is hashed (8 key bits per cycle), its home slot is brought inside
// the span, then slots are probed in turn from the home slot; the result is
// registered after the last probe. A zero key is answered without hashing.
// After reset busy stays high while the key store is swept to empty. The
// result channel cannot stall.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
    parameter int unsigned TABLE_DEPTH  = 64,
    parameter int unsigned HASH_MODULUS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  lph_pkg::t_req              i_req,
    output logic                       o_valid,
    output lph_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic [lph_pkg::SPAN_W-1:0] i_cfg_wdata
);
    import lph_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    lph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    lph_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .HASH_MODULUS (HASH_MODULUS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rsp       (o_rsp)
    );

`ifndef SYNTHESIS
    // A result is only ever delivered once the controller is back at rest.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // No request is answered in the cycle straight after its transfer.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result too soon after request transfer");

    // Only inserted or found results carry a slot number.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status != ST_INSERTED && o_rsp.status != ST_FOUND)
        |-> (o_rsp.slot == '0))
        else $error("slot not zero on miss or error");
`endif

endmodule
